FILE: src/integer_to_radix_ascii_macros.svh
// Assertion macros used by the checker of the integer to radix text converter.
// Included by bare file name; needs nothing else.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define ITRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define ITRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/itra_pkg.sv
// Types, constants and helper functions for the integer to radix text converter.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package itra_pkg;

    // Input beat: value to convert and the radix to use.
    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         radix;
    } t_in;

    // Output beat: one character of text.
    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
        logic       error;
    } t_out;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    // Status from the shared divider back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic quot_zero;
    } t_div_stat;

    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] RADIX_TEN  = 6'd10;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_A     = 7'h61;
    localparam logic [6:0] CHAR_Z     = 7'h7a;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] DIGIT_MAX  = 7'd9;
    localparam logic [6:0] DIGIT_TEN  = 7'd10;

    // Map a digit value 0..35 to its ASCII character.
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] dx;
        dx = {1'b0, d};
        if (dx > DIGIT_MAX) begin
            return CHAR_A + (dx - DIGIT_TEN);
        end
        return CHAR_ZERO + dx;
    endfunction

endpackage

FILE: src/itra_divider.sv
// Shared radix-2 restoring divider: one quotient bit per cycle, quotient built in place.
// Depends on itra_pkg for the status struct.
`timescale 1ns / 1ps

module itra_divider
    import itra_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [WORD_BITS-1:0] i_load_mag,
    input  logic                 i_start,
    input  logic [5:0]           i_radix,
    output t_div_stat            o_stat,
    output logic [5:0]           o_digit
);

    localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [BW-1:0] LAST_BIT = BW'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_mag;
    logic [5:0]           r_rem;
    logic [BW-1:0]        r_bits;
    logic                 r_busy;
    logic                 r_done;

    logic [6:0]           rem_sh;
    logic                 ge;
    logic [6:0]           rem_nx;

    // One shift, compare and subtract step
    always_comb begin
        rem_sh = {r_rem, r_mag[WORD_BITS-1]};
        ge     = (rem_sh >= {1'b0, i_radix});
        rem_nx = ge ? (rem_sh - {1'b0, i_radix}) : rem_sh;
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bits <= '0;
            end else if (r_busy) begin
                r_bits <= r_bits + 1'b1;
                if (r_bits == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and magnitude/quotient register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= i_load_mag;
        end else if (r_busy && !i_start) begin
            r_mag <= {r_mag[WORD_BITS-2:0], ge};
        end
        if (i_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= rem_nx[5:0];
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.done      = r_done;
    assign o_stat.quot_zero = (r_mag == '0);
    assign o_digit          = r_rem;

endmodule

FILE: src/integer_to_radix_ascii.sv
// Top level of the integer to radix text converter.
// Depends on itra_pkg and itra_divider.
`timescale 1ns / 1ps

// Converts a signed integer to ASCII text in a radix from 2 to 36, one character per
// output beat, most significant first, last flagged on the final character. A minus sign
// leads only for negative values in base 10; in other radices a negative value is
// converted as its WORD_BITS-bit unsigned pattern. A radix outside 2..36 gives one beat
// with error set and char_code 0. Digits come from a single shared restoring divider that
// produces one quotient bit per cycle; the digits are kept in a small store and then read
// back in reverse, each character through a read state and an emit state. The input is
// not ready while a conversion runs; the final character may still wait in the output
// register while the next item is taken.
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CW = $clog2(WORD_BITS + 1);

    t_state               r_state, n_state;
    logic [5:0]           r_radix, n_radix;
    logic                 r_neg, n_neg;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    t_out                 r_out;
    logic [5:0]           r_rd_data;
    logic [5:0]           r_mem [WORD_BITS];

    logic                 out_free;
    logic                 out_load;
    t_out                 out_beat;
    logic                 div_load;
    logic                 div_start;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] load_mag;
    logic                 in_neg;
    logic                 radix_ok;
    logic                 store_we;
    logic [AW-1:0]        rd_addr;
    t_div_stat            div_stat;
    logic [5:0]           div_digit;

    // Shared divider
    itra_divider #(
        .WORD_BITS(WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_load_mag (load_mag),
        .i_start    (div_start),
        .i_radix    (r_radix),
        .o_stat     (div_stat),
        .o_digit    (div_digit)
    );

    // Prepare the magnitude: sign-extend or truncate, negate only for decimal
    always_comb begin
        word     = WORD_BITS'(i_in_data.value);
        radix_ok = (i_in_data.radix >= RADIX_MIN) && (i_in_data.radix <= RADIX_MAX);
        in_neg   = i_in_data.value[31] && (i_in_data.radix == RADIX_TEN);
        load_mag = in_neg ? ((~word) + 1'b1) : word;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign rd_addr  = AW'(r_count - 1'b1);

    // Sequencer: next state and control
    always_comb begin
        n_state    = r_state;
        n_radix    = r_radix;
        n_neg      = r_neg;
        n_count    = r_count;
        out_load   = 1'b0;
        out_beat   = '0;
        div_load   = 1'b0;
        div_start  = 1'b0;
        store_we   = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (radix_ok) begin
                        n_radix   = i_in_data.radix;
                        n_neg     = in_neg;
                        n_count   = '0;
                        div_load  = 1'b1;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_beat.last  = 1'b1;
                    out_beat.error = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    store_we = 1'b1;
                    n_count  = r_count + 1'b1;
                    if (div_stat.quot_zero) begin
                        n_state = r_neg ? S_SIGN : S_READ;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_beat.char_code = CHAR_MINUS;
                    n_state            = S_READ;
                end
            end
            S_READ: begin
                n_count = r_count - 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_beat.char_code = digit_char(r_rd_data);
                    out_beat.last      = (r_count == '0);
                    n_state            = (r_count == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        if (out_load) begin
            r_out <= out_beat;
        end
    end

    // Digit store: write at the fill count, read back in reverse and hold while emitting
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_mem[r_count[AW-1:0]] <= div_digit;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/itra_checker.sv
// Port-level checker for the integer to radix text converter, bound to the top level.
// Depends on itra_pkg and integer_to_radix_ascii_macros.svh.
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_macros.svh"

module itra_checker
    import itra_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic char_legal;

    // A character beat is a digit, a lower-case letter or the minus sign
    assign char_legal = ((o_out_data.char_code >= CHAR_ZERO) && (o_out_data.char_code <= CHAR_NINE))
                     || ((o_out_data.char_code >= CHAR_A) && (o_out_data.char_code <= CHAR_Z))
                     || (o_out_data.char_code == CHAR_MINUS);

    // An error beat is a lone, empty, final beat
    `ITRA_ASSERT_IMP(a_err_beat, i_clk, i_rst_n, o_out_valid && o_out_data.error, (o_out_data.char_code == '0) && o_out_data.last, "error beat must be last with char_code 0")

    // Normal beats only carry legal characters
    `ITRA_ASSERT_IMP(a_char_legal, i_clk, i_rst_n, o_out_valid && !o_out_data.error, char_legal, "illegal character code")

    // The sign always has digits after it
    `ITRA_ASSERT_IMP(a_sign_not_last, i_clk, i_rst_n, o_out_valid && (o_out_data.char_code == CHAR_MINUS), !o_out_data.last, "minus sign marked last")

    // A conversion never starts back to back with the previous one
    `ITRA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after an accepted beat")

    // A stalled output beat holds
    `ITRA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output beat changed while stalled")

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: sim/tb_integer_to_radix_ascii.sv
// Self-checking testbench for integer_to_radix_ascii: a directed table, then random beats.
// Depends on itra_pkg and the integer_to_radix_ascii RTL; reads no files.
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;
    import itra_pkg::*;

    localparam int RANDOM_ITEMS  = 200;
    localparam int CALM_FROM     = 80;      // random beats in [CALM_FROM, CALM_TO) never idle
    localparam int CALM_TO       = 130;
    localparam int HOLD_AFTER    = 600;     // output beats seen before the long hold-off
    localparam int HOLD_CYCLES   = 2500;
    localparam int WATCH_LIMIT   = 20000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = 1200;    // one worst-case conversion
    localparam int MAX_PRINTS    = 50;
    localparam int DIR_ROWS      = 24;

    localparam t_out BAD_RADIX_BEAT = '{char_code: 7'd0, last: 1'b1, error: 1'b1};

    typedef enum logic [1:0] {
        ROW_MODEL,      // expected text from the predictor
        ROW_TEXT,       // expected text typed in
        ROW_ERROR       // radix out of range
    } t_row_kind;

    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         radix;
        t_row_kind          kind;
        string              text;
    } t_dir_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    logic calm        = 1'b0;
    int   out_beats   = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    int   idle_cycles = 0;
    int   mismatches  = 0;

    t_out     expected_chars[$];
    t_dir_row dir_table[DIR_ROWS];

    integer_to_radix_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Work out the characters one beat must produce and queue them.
    function automatic void predict_text(input t_in beat);
        logic [31:0] rest;
        logic [31:0] base;
        logic [5:0]  digits[$];
        logic        minus;
        logic [6:0]  code;
        if (beat.radix < RADIX_MIN || beat.radix > RADIX_MAX) begin
            expected_chars.push_back(BAD_RADIX_BEAT);
            return;
        end
        base  = {26'd0, beat.radix};
        minus = beat.value[31] && (beat.radix == RADIX_TEN);
        rest  = beat.value;
        // negate for the decimal sign; the most negative value stays 2^31 unsigned
        if (minus) begin
            rest = ~rest + 32'd1;
            expected_chars.push_back('{char_code: CHAR_MINUS, last: 1'b0, error: 1'b0});
        end
        do begin
            digits.push_front(6'(rest % base));
            rest = rest / base;
        end while (rest != 32'd0);
        foreach (digits[i]) begin
            if (digits[i] < 6'd10) begin
                code = CHAR_ZERO + 7'(digits[i]);
            end else begin
                code = CHAR_A + 7'(digits[i] - 6'd10);
            end
            expected_chars.push_back('{char_code: code, last: (i == digits.size() - 1),
                                       error: 1'b0});
        end
    endfunction

    // Queue a typed-in expected string, last set on its final character.
    function automatic void queue_typed_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            expected_chars.push_back('{char_code: 7'(text[i]), last: (i == text.len() - 1),
                                       error: 1'b0});
        end
    endfunction

    // Random beat: mostly valid radices, a tenth out of range, values spread over the range.
    function automatic t_in random_beat();
        t_in b;
        int  pick;
        int  idx;
        pick = $urandom_range(99);
        if (pick < 10) begin
            idx     = $urandom_range(28);
            b.radix = (idx < 2) ? 6'(idx) : 6'(idx + 35);
        end else if (pick < 35) begin
            b.radix = RADIX_TEN;
        end else begin
            b.radix = 6'($urandom_range(36, 2));
        end
        case ($urandom_range(3))
            0: b.value = $urandom;
            1: b.value = 32'($urandom_range(1000));
            2: b.value = 32'd0 - 32'($urandom_range(1000));
            default: b.value = $urandom_range(1) ? (32'h7fff_ffff - 32'($urandom_range(15)))
                                                 : (32'h8000_0000 + 32'($urandom_range(15)));
        endcase
        return b;
    endfunction

    // Print one line per mismatch (up to a cap) and count it.
    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Offer one input beat after a random gap; return at the edge that accepts it.
    task automatic offer_beat(input t_in beat);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sink side: random stalls, one long hold-off once enough beats have gone by.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && out_beats >= HOLD_AFTER) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // Compare each output beat with the oldest expected character.
    always @(posedge i_clk) begin : check_chars
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_beats <= out_beats + 1;
            if (expected_chars.size() == 0) begin
                flag_mismatch($sformatf("beat %h with nothing expected", o_out_data));
            end else begin
                want = expected_chars.pop_front();
                if (o_out_data.char_code !== want.char_code) begin
                    flag_mismatch($sformatf("char_code %h, want %h",
                                            o_out_data.char_code, want.char_code));
                end
                if (o_out_data.last !== want.last) begin
                    flag_mismatch($sformatf("last %b, want %b", o_out_data.last, want.last));
                end
                if (o_out_data.error !== want.error) begin
                    flag_mismatch($sformatf("error %b, want %b",
                                            o_out_data.error, want.error));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("integer_to_radix_ascii regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_in beat;
        dir_table = '{
            '{32'sd0,          6'd10, ROW_TEXT,  "0"},
            '{32'sd0,          6'd2,  ROW_TEXT,  "0"},
            '{32'sd0,          6'd36, ROW_TEXT,  "0"},
            '{32'sh7fff_ffff,  6'd10, ROW_TEXT,  "2147483647"},
            '{32'sh8000_0000,  6'd10, ROW_TEXT,  "-2147483648"},
            '{32'shffff_ffff,  6'd10, ROW_TEXT,  "-1"},
            '{32'shffff_ffff,  6'd16, ROW_TEXT,  "ffffffff"},
            '{32'shffff_ffff,  6'd2,  ROW_TEXT,  "11111111111111111111111111111111"},
            '{32'sh8000_0000,  6'd16, ROW_TEXT,  "80000000"},
            '{32'sh8000_0000,  6'd2,  ROW_MODEL, ""},
            '{32'sh7fff_ffff,  6'd36, ROW_MODEL, ""},
            '{32'shffff_ffff,  6'd36, ROW_MODEL, ""},
            '{32'sd35,         6'd36, ROW_TEXT,  "z"},
            '{32'sd36,         6'd36, ROW_TEXT,  "10"},
            '{32'sd255,        6'd16, ROW_TEXT,  "ff"},
            '{32'sd1,          6'd2,  ROW_TEXT,  "1"},
            '{-32'sd12345,     6'd10, ROW_TEXT,  "-12345"},
            '{32'sd12345,      6'd8,  ROW_TEXT,  "30071"},
            '{32'shaaaa_aaaa,  6'd3,  ROW_MODEL, ""},
            '{32'sh5555_5555,  6'd7,  ROW_MODEL, ""},
            '{32'sd100,        6'd0,  ROW_ERROR, ""},
            '{32'sd100,        6'd1,  ROW_ERROR, ""},
            '{32'shffff_ffff,  6'd37, ROW_ERROR, ""},
            '{32'sd0,          6'd63, ROW_ERROR, ""}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            beat.value = dir_table[r].value;
            beat.radix = dir_table[r].radix;
            offer_beat(beat);
            case (dir_table[r].kind)
                ROW_TEXT:  queue_typed_text(dir_table[r].text);
                ROW_ERROR: expected_chars.push_back(BAD_RADIX_BEAT);
                default:   predict_text(beat);
            endcase
        end

        // Random beats, with a stretch of no idling on either side
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm <= (k >= CALM_FROM && k < CALM_TO);
            beat = random_beat();
            offer_beat(beat);
            predict_text(beat);
        end
        i_in_valid <= 1'b0;
        calm       <= 1'b0;

        // Drain, then allow one more conversion's worth of cycles for stray beats
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("integer_to_radix_ascii regression: pass");
        end else begin
            $display("integer_to_radix_ascii regression: fail");
        end
        $finish;
    end

endmodule
